/* hdl/bcgm_pkg.sv */
// shared types, widths and constants for the bezier color gradient map
package bcgm_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int NCH         = 3;
    localparam int CH_W        = 8;
    localparam int RGB_W       = NCH * CH_W;
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int PR_W        = PROD_W + CH_W;
    localparam int NUM_W       = PROD_W + 9;
    localparam int DEN_W       = PROD_W + 1;
    localparam int DIV_STEPS   = CH_W;
    localparam int CFG_W       = (VALUE_WIDTH > RGB_W) ? VALUE_WIDTH : RGB_W;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [VALUE_WIDTH-1:0]        uval_t;
    typedef logic [PROD_W-1:0]             prod_t;
    typedef logic [PR_W-1:0]               wprod_t;
    typedef logic [NUM_W-1:0]              num_t;
    typedef logic [DEN_W-1:0]              den_t;
    typedef logic [NCH-1:0][CH_W-1:0]      rgb_t;

    typedef enum logic [2:0] {
        REG_START_TH  = 3'd0,
        REG_MID_TH    = 3'd1,
        REG_END_TH    = 3'd2,
        REG_COL_START = 3'd3,
        REG_COL_MID1  = 3'd4,
        REG_COL_MID2  = 3'd5,
        REG_COL_MID3  = 3'd6,
        REG_COL_END   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        value_t start_th;
        value_t mid_th;
        value_t end_th;
        rgb_t   color_start;
        rgb_t   color_mid_one;
        rgb_t   color_mid_two;
        rgb_t   color_mid_three;
        rgb_t   color_end;
    } cfg_t;

    localparam value_t RST_START_TH  = VALUE_WIDTH'(0);
    localparam value_t RST_MID_TH    = VALUE_WIDTH'(255);
    localparam value_t RST_END_TH    = VALUE_WIDTH'(500);
    localparam rgb_t   RST_COL_START = 24'h00FFFF;
    localparam rgb_t   RST_COL_MID1  = 24'h1E50FF;
    localparam rgb_t   RST_COL_MID2  = 24'h28FF3C;
    localparam rgb_t   RST_COL_MID3  = 24'hA0800A;
    localparam rgb_t   RST_COL_END   = 24'hFF4500;

    // curve point u = n/d with the three control colors of the segment
    typedef struct packed {
        uval_t n;
        uval_t d;
        rgb_t  c1;
        rgb_t  c2;
        rgb_t  c3;
    } sel_beat_t;

    // per channel numerator over the common denominator 2*d*d
    typedef struct packed {
        logic [NCH-1:0][NUM_W-1:0] num;
        den_t                      den;
    } sum_beat_t;

endpackage

/* hdl/bcgm_ifs.sv */
// stream interfaces for the level input and the color output
interface bcgm_level_if;
    import bcgm_pkg::*;
    logic   valid;
    logic   ready;
    value_t level;
    modport source (output valid, output level, input ready);
    modport sink (input valid, input level, output ready);
endinterface

interface bcgm_rgb_if;
    import bcgm_pkg::*;
    logic valid;
    logic ready;
    rgb_t rgb;
    modport source (output valid, output rgb, input ready);
    modport sink (input valid, input rgb, output ready);
endinterface

/* hdl/bezier_color_gradient_map.sv */
// top level of the quadratic bezier color gradient map
//
//  port       dir   role
//  samples    sink  level beats, signed value to map
//  colors     src   rgb beats, packed 24-bit color
//  cfg_*      in    register writes, index 0..7
//
// one beat per cycle while colors is not stalled; stages from accepted level to valid color
// (1 select, 3 multiply/sum, 8 divider bit stages, 1 output register)
// the eight divider stages resolve one quotient bit each
// a stalled color freezes the whole pipeline; nothing in flight is lost
// reset clears valid bits and loads the default thresholds and colors
module bezier_color_gradient_map (
    input  logic                        clk,
    input  logic                        rst_n,
    bcgm_level_if.sink                  samples,
    bcgm_rgb_if.source                  colors,
    input  logic                        cfg_we,
    input  bcgm_pkg::cfg_index_t        cfg_index,
    input  logic [bcgm_pkg::CFG_W-1:0]  cfg_data
);
    import bcgm_pkg::*;

    cfg_t       cfg_reg;
    logic       adv;
    logic       sel_valid;
    sel_beat_t  sel_beat;
    logic       sum_valid;
    sum_beat_t  sum_beat;
    logic       div_valid;
    rgb_t       div_q;
    logic       out_valid_reg;
    rgb_t       rgb_reg;

    assign adv           = !out_valid_reg || colors.ready;
    assign samples.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_th        <= RST_START_TH;
            cfg_reg.mid_th          <= RST_MID_TH;
            cfg_reg.end_th          <= RST_END_TH;
            cfg_reg.color_start     <= RST_COL_START;
            cfg_reg.color_mid_one   <= RST_COL_MID1;
            cfg_reg.color_mid_two   <= RST_COL_MID2;
            cfg_reg.color_mid_three <= RST_COL_MID3;
            cfg_reg.color_end       <= RST_COL_END;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_TH:  cfg_reg.start_th        <= cfg_data[VALUE_WIDTH-1:0];
                REG_MID_TH:    cfg_reg.mid_th          <= cfg_data[VALUE_WIDTH-1:0];
                REG_END_TH:    cfg_reg.end_th          <= cfg_data[VALUE_WIDTH-1:0];
                REG_COL_START: cfg_reg.color_start     <= cfg_data[RGB_W-1:0];
                REG_COL_MID1:  cfg_reg.color_mid_one   <= cfg_data[RGB_W-1:0];
                REG_COL_MID2:  cfg_reg.color_mid_two   <= cfg_data[RGB_W-1:0];
                REG_COL_MID3:  cfg_reg.color_mid_three <= cfg_data[RGB_W-1:0];
                REG_COL_END:   cfg_reg.color_end       <= cfg_data[RGB_W-1:0];
                default:       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    bcgm_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (samples.valid),
        .level     (samples.level),
        .cfg       (cfg_reg),
        .sel_valid (sel_valid),
        .sel_beat  (sel_beat)
    );

    bcgm_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .sel_valid (sel_valid),
        .sel_beat  (sel_beat),
        .sum_valid (sum_valid),
        .sum_beat  (sum_beat)
    );

    bcgm_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .sum_valid (sum_valid),
        .sum_beat  (sum_beat),
        .div_valid (div_valid),
        .div_q     (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && div_valid)
        begin
            rgb_reg <= div_q;
        end
    end

    assign colors.valid = out_valid_reg;
    assign colors.rgb   = rgb_reg;

    // a stalled color beat must hold the input side closed
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        colors.valid && !colors.ready |-> !samples.ready)
        else $error("input accepted while output stalled");

    // a new color beat only comes out of a valid divider stage
    a_out_from_divider: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(colors.valid) |-> $past(div_valid))
        else $error("color beat without divider result");

    // a frozen pipeline keeps its last divider and sum valid bits
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(div_valid) && $stable(sum_valid))
        else $error("pipeline moved during stall");

endmodule

/* hdl/bcgm_select.sv */
// segment select stage: thresholds, curve parameter and control colors
module bcgm_select (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  bcgm_pkg::value_t      level,
    input  bcgm_pkg::cfg_t        cfg,
    output logic                  sel_valid,
    output bcgm_pkg::sel_beat_t   sel_beat
);
    import bcgm_pkg::*;

    logic                   valid_reg;
    sel_beat_t              beat_reg;
    sel_beat_t              beat_next;
    logic [VALUE_WIDTH:0]   diff_xs;
    logic [VALUE_WIDTH:0]   diff_xm;
    logic [VALUE_WIDTH:0]   diff_ms;
    logic [VALUE_WIDTH:0]   diff_em;

    always_comb
    begin
        diff_xs = {level[VALUE_WIDTH-1], level} - {cfg.start_th[VALUE_WIDTH-1], cfg.start_th};
        diff_xm = {level[VALUE_WIDTH-1], level} - {cfg.mid_th[VALUE_WIDTH-1], cfg.mid_th};
        diff_ms = {cfg.mid_th[VALUE_WIDTH-1], cfg.mid_th}
                - {cfg.start_th[VALUE_WIDTH-1], cfg.start_th};
        diff_em = {cfg.end_th[VALUE_WIDTH-1], cfg.end_th}
                - {cfg.mid_th[VALUE_WIDTH-1], cfg.mid_th};

        // flat ends use u = 0 over d = 1, which yields c1 exactly
        beat_next.n  = '0;
        beat_next.d  = VALUE_WIDTH'(1);
        beat_next.c1 = cfg.color_start;
        beat_next.c2 = '0;
        beat_next.c3 = '0;
        if (level <= cfg.start_th)
        begin
            beat_next.c1 = cfg.color_start;
        end
        else if (level > cfg.end_th)
        begin
            beat_next.c1 = cfg.color_end;
        end
        else if (level <= cfg.mid_th)
        begin
            beat_next.n  = diff_xs[VALUE_WIDTH-1:0];
            beat_next.d  = diff_ms[VALUE_WIDTH-1:0];
            beat_next.c1 = cfg.color_start;
            beat_next.c2 = cfg.color_mid_one;
            beat_next.c3 = cfg.color_mid_two;
        end
        else
        begin
            beat_next.n  = diff_xm[VALUE_WIDTH-1:0];
            beat_next.d  = diff_em[VALUE_WIDTH-1:0];
            beat_next.c1 = cfg.color_mid_two;
            beat_next.c2 = cfg.color_mid_three;
            beat_next.c3 = cfg.color_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign sel_valid = valid_reg;
    assign sel_beat  = beat_reg;

endmodule

/* hdl/bcgm_product.sv */
// squares, channel weighting and numerator sum over three stages
module bcgm_product (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  sel_valid,
    input  bcgm_pkg::sel_beat_t   sel_beat,
    output logic                  sum_valid,
    output bcgm_pkg::sum_beat_t   sum_beat
);
    import bcgm_pkg::*;

    // stage one: products of the curve terms
    logic                       v1_reg;
    prod_t                      aa_reg, an_reg, nn_reg, dd_reg;
    rgb_t                       c1_reg, c2_reg, c3_reg;
    uval_t                      a_dist;
    // stage two: color weighted terms
    logic                       v2_reg;
    logic [NCH-1:0][PR_W-1:0]   p1_reg, p2_reg, p3_reg;
    prod_t                      dd2_reg;
    // stage three: numerator and denominator
    logic                       v3_reg;
    sum_beat_t                  sum_reg;
    sum_beat_t                  sum_next;
    logic [PR_W:0]              s13;

    assign a_dist = sel_beat.d - sel_beat.n;

    always_comb
    begin
        sum_next.den = {dd2_reg, 1'b0};
        for (int ch = 0; ch < NCH; ch++)
        begin
            s13 = (PR_W+1)'(p1_reg[ch]) + (PR_W+1)'(p3_reg[ch]);
            sum_next.num[ch] = NUM_W'({s13, 1'b0}) + NUM_W'({p2_reg[ch], 2'b00})
                             + NUM_W'(dd2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= sel_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            aa_reg <= PROD_W'(a_dist) * PROD_W'(a_dist);
            an_reg <= PROD_W'(a_dist) * PROD_W'(sel_beat.n);
            nn_reg <= PROD_W'(sel_beat.n) * PROD_W'(sel_beat.n);
            dd_reg <= PROD_W'(sel_beat.d) * PROD_W'(sel_beat.d);
            c1_reg <= sel_beat.c1;
            c2_reg <= sel_beat.c2;
            c3_reg <= sel_beat.c3;

            for (int ch = 0; ch < NCH; ch++)
            begin
                p1_reg[ch] <= PR_W'(c1_reg[ch]) * PR_W'(aa_reg);
                p2_reg[ch] <= PR_W'(c2_reg[ch]) * PR_W'(an_reg);
                p3_reg[ch] <= PR_W'(c3_reg[ch]) * PR_W'(nn_reg);
            end
            dd2_reg <= dd_reg;

            sum_reg <= sum_next;
        end
    end

    assign sum_valid = v3_reg;
    assign sum_beat  = sum_reg;

endmodule

/* hdl/bcgm_divide.sv */
// pipelined restoring divider, one quotient bit per stage for all channels
module bcgm_divide (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  sum_valid,
    input  bcgm_pkg::sum_beat_t   sum_beat,
    output logic                  div_valid,
    output bcgm_pkg::rgb_t        div_q
);
    import bcgm_pkg::*;

    logic [DIV_STEPS-1:0]       v_reg;
    logic [NCH-1:0][NUM_W-1:0]  r_reg    [DIV_STEPS];
    logic [NCH-1:0][NUM_W-1:0]  r_next   [DIV_STEPS];
    den_t                       den_reg  [DIV_STEPS];
    den_t                       den_next [DIV_STEPS];
    rgb_t                       q_reg    [DIV_STEPS];
    rgb_t                       q_next   [DIV_STEPS];

    always_comb
    begin
        num_t rem;
        num_t trial;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                den_next[k] = sum_beat.den;
                q_next[k]   = '0;
                r_next[k]   = sum_beat.num;
            end
            else
            begin
                den_next[k] = den_reg[k-1];
                q_next[k]   = q_reg[k-1];
                r_next[k]   = r_reg[k-1];
            end
            trial = NUM_W'(den_next[k]) << (DIV_STEPS - 1 - k);
            for (int ch = 0; ch < NCH; ch++)
            begin
                rem = r_next[k][ch];
                if (trial <= rem)
                begin
                    r_next[k][ch] = rem - trial;
                    q_next[k][ch][DIV_STEPS-1-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DIV_STEPS-2:0], sum_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                r_reg[k]   <= r_next[k];
                den_reg[k] <= den_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign div_valid = v_reg[DIV_STEPS-1];
    assign div_q     = q_reg[DIV_STEPS-1];

endmodule
